// ----- src/stream_substring_replace_assert.svh -----
// Assertion macros used by the checker file of this block.
`ifndef STREAM_SUBSTRING_REPLACE_ASSERT_SVH
`define STREAM_SUBSTRING_REPLACE_ASSERT_SVH

// Clocked check, off while reset is asserted.
`define SSR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("stream_substring_replace: port check failed");

// Clocked check that also runs during reset.
`define SSR_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("stream_substring_replace: reset check failed");

`endif

// ----- src/ssr_pkg.sv -----
package ssr_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MAX_BYTES = 8;    // bytes in a pattern or replacement register
    localparam int unsigned SEL_W     = 3;    // selects one of MAX_BYTES
    localparam int unsigned LEN_W     = 4;    // length fields and result counts
    localparam int unsigned CFG_W     = 64;
    localparam int unsigned IDX_W     = 2;
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_PTR_W   = 1;
    localparam int unsigned Q_FILL_W  = 2;

    typedef enum logic [IDX_W-1:0] {
        REG_PATTERN_LEN   = 2'd0,
        REG_PATTERN_BYTES = 2'd1,
        REG_REPLACE_LEN   = 2'd2,
        REG_REPLACE_BYTES = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_string;
    } in_word_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              byte_valid;
        logic              final_result;
    } out_word_t;

    typedef enum logic {
        SRC_WINDOW  = 1'b0,
        SRC_REPLACE = 1'b1
    } src_t;

    // One entry of work for the output sequencer: emit count bytes from the
    // chosen source, then an end marker if mark is set.
    typedef struct packed {
        src_t                              src;
        logic [LEN_W-1:0]                  count;
        logic                              mark;
        logic [MAX_BYTES-1:0][BYTE_W-1:0]  bytes;
    } cmd_t;

endpackage

// ----- src/stream_substring_replace.sv -----
// Streaming find-and-replace: bytes enter one word per cycle on in_data with an
// end_of_string flag; every leftmost, non-overlapping occurrence of the pattern
// (pattern_len bytes, 0 taken as 1, capped at MAX_PATTERN) is replaced by the
// first replace_len bytes (capped at 8) of replace_bytes, all other bytes pass
// through in order, and each string ends with a bare marker word
// (byte_valid = 0, final_result = 1). The front stage updates the match window
// and takes one input word per cycle as long as its two-entry work queue has
// room; the output sequencer then emits one result word per cycle while
// out_ready is high. An input word yields a replacement burst of up to 8
// bytes, an end-of-string flush of up to MAX_PATTERN + 1 words, or no result,
// in which case it takes no queue entry.
// Write configuration only while the block is idle.
module stream_substring_replace #(
    parameter int unsigned MAX_PATTERN = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  ssr_pkg::in_word_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output ssr_pkg::out_word_t          out_data,
    input  logic                        cfg_write,
    input  logic [ssr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ssr_pkg::CFG_W-1:0]   cfg_data
);

    // Configuration registers.
    logic [ssr_pkg::LEN_W-1:0]  pattern_len_reg;
    logic [ssr_pkg::CFG_W-1:0]  pattern_bytes_reg;
    logic [ssr_pkg::LEN_W-1:0]  replace_len_reg;
    logic [ssr_pkg::CFG_W-1:0]  replace_bytes_reg;

    logic [ssr_pkg::LEN_W-1:0]  plen_eff, rlen_eff;
    logic                       push, push_ready, pop, head_valid;
    ssr_pkg::cmd_t              push_cmd, head_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg   <= ssr_pkg::LEN_W'(1);
            pattern_bytes_reg <= '0;
            replace_len_reg   <= '0;
            replace_bytes_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (ssr_pkg::reg_index_t'(cfg_index))
                ssr_pkg::REG_PATTERN_LEN:   pattern_len_reg   <= cfg_data[ssr_pkg::LEN_W-1:0];
                ssr_pkg::REG_PATTERN_BYTES: pattern_bytes_reg <= cfg_data;
                ssr_pkg::REG_REPLACE_LEN:   replace_len_reg   <= cfg_data[ssr_pkg::LEN_W-1:0];
                ssr_pkg::REG_REPLACE_BYTES: replace_bytes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp lengths: empty pattern counts as one byte, long ones saturate.
    always_comb
    begin
        priority if (pattern_len_reg == '0)
        begin
            plen_eff = ssr_pkg::LEN_W'(1);
        end
        else if (pattern_len_reg > ssr_pkg::LEN_W'(MAX_PATTERN))
        begin
            plen_eff = ssr_pkg::LEN_W'(MAX_PATTERN);
        end
        else
        begin
            plen_eff = pattern_len_reg;
        end
        rlen_eff = (replace_len_reg > ssr_pkg::LEN_W'(ssr_pkg::MAX_BYTES))
                 ? ssr_pkg::LEN_W'(ssr_pkg::MAX_BYTES) : replace_len_reg;
    end

    // Front: hold the window, classify each word into a work entry.
    ssr_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .plen       (plen_eff),
        .rlen       (rlen_eff),
        .pattern    (pattern_bytes_reg),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    // Decouple front and back so either side can stall.
    ssr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    // Back: expand each entry into result words through the output register.
    ssr_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_cmd   (head_cmd),
        .head_valid (head_valid),
        .pop        (pop),
        .replace    (replace_bytes_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

// ----- src/ssr_queue.sv -----
module ssr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ssr_pkg::cmd_t push_cmd,
    output logic          push_ready,
    input  logic          pop,
    output ssr_pkg::cmd_t head_cmd,
    output logic          head_valid
);

    ssr_pkg::cmd_t                   entry_reg [ssr_pkg::Q_DEPTH];
    logic [ssr_pkg::Q_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ssr_pkg::Q_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ssr_pkg::Q_FILL_W-1:0]    fill_reg, fill_next;
    logic                            do_push, do_pop;

    assign push_ready = (fill_reg != ssr_pkg::Q_FILL_W'(ssr_pkg::Q_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- src/ssr_front.sv -----
module ssr_front #(
    parameter int unsigned MAX_PATTERN = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  ssr_pkg::in_word_t                     in_data,
    input  logic [ssr_pkg::LEN_W-1:0]             plen,
    input  logic [ssr_pkg::LEN_W-1:0]             rlen,
    input  logic [ssr_pkg::MAX_BYTES-1:0][ssr_pkg::BYTE_W-1:0] pattern,
    output logic                                  push,
    output ssr_pkg::cmd_t                         push_cmd,
    input  logic                                  push_ready
);

    localparam int unsigned CW = $clog2(MAX_PATTERN + 1);

    logic [ssr_pkg::BYTE_W-1:0] win_reg  [MAX_PATTERN];
    logic [ssr_pkg::BYTE_W-1:0] win_next [MAX_PATTERN];
    logic [ssr_pkg::BYTE_W-1:0] comb     [MAX_PATTERN];
    logic [CW-1:0]              count_reg, count_next;
    logic [ssr_pkg::LEN_W-1:0]  cnt_ext, total, pop_n;
    logic                       accept, hit, over, full, clear, eos;

    assign in_ready = push_ready;
    assign accept   = in_valid && push_ready;
    assign eos      = in_data.end_of_string;

    always_comb
    begin
        cnt_ext = ssr_pkg::LEN_W'(count_reg);
        total   = cnt_ext + 1'b1;
        // Append the new byte behind the held ones.
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            comb[j] = (ssr_pkg::LEN_W'(j) == cnt_ext) ? in_data.in_byte : win_reg[j];
        end
        hit = 1'b1;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (ssr_pkg::LEN_W'(j) < plen && comb[j] != pattern[j])
            begin
                hit = 1'b0;
            end
        end
        over  = (cnt_ext >= plen);
        full  = (total == plen);
        clear = 1'b0;
        pop_n = '0;
        priority if (over)
        begin
            // Pattern shrank: shift out down to one byte short of it, or all at end of string.
            pop_n = eos ? total : total - plen + 1'b1;
        end
        else if (full && hit)
        begin
            clear = 1'b1;
        end
        else if (full)
        begin
            pop_n = eos ? total : ssr_pkg::LEN_W'(1);
        end
        else
        begin
            pop_n = eos ? total : '0;
        end

        push_cmd       = '0;
        push_cmd.src   = clear ? ssr_pkg::SRC_REPLACE : ssr_pkg::SRC_WINDOW;
        push_cmd.count = clear ? rlen : pop_n;
        push_cmd.mark  = eos;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            push_cmd.bytes[j] = comb[j];
        end
        push = accept && (push_cmd.count != '0 || eos);

        count_next = clear ? '0 : CW'(total - pop_n);
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            win_next[j] = win_reg[j];
            for (int k = 0; k < MAX_PATTERN; k++)
            begin
                if (ssr_pkg::LEN_W'(k) == ssr_pkg::LEN_W'(j) + pop_n)
                begin
                    win_next[j] = comb[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg <= win_next;
        end
    end

endmodule

// ----- src/ssr_back.sv -----
module ssr_back (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  ssr_pkg::cmd_t                         head_cmd,
    input  logic                                  head_valid,
    output logic                                  pop,
    input  logic [ssr_pkg::MAX_BYTES-1:0][ssr_pkg::BYTE_W-1:0] replace,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output ssr_pkg::out_word_t                    out_data
);

    logic [ssr_pkg::LEN_W-1:0]  idx_reg, idx_next;
    logic                       out_valid_reg, out_valid_next;
    ssr_pkg::out_word_t         out_data_reg, out_data_next;
    logic                       load, is_byte, last;
    logic [ssr_pkg::SEL_W-1:0]  sel;
    logic [ssr_pkg::BYTE_W-1:0] byte_sel;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        load    = head_valid && (!out_valid_reg || out_ready);
        is_byte = (idx_reg < head_cmd.count);
        last    = head_cmd.mark ? (idx_reg == head_cmd.count)
                                : (idx_reg == head_cmd.count - 1'b1);
        sel     = idx_reg[ssr_pkg::SEL_W-1:0];
        unique case (head_cmd.src)
            ssr_pkg::SRC_REPLACE: byte_sel = replace[sel];
            ssr_pkg::SRC_WINDOW:  byte_sel = head_cmd.bytes[sel];
            default:              byte_sel = '0;
        endcase
        pop = load && last;

        out_data_next.out_byte     = is_byte ? byte_sel : '0;
        out_data_next.byte_valid   = is_byte;
        out_data_next.final_result = !is_byte;

        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            idx_next       = last ? '0 : idx_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ----- src/ssr_checker.sv -----
`include "stream_substring_replace_assert.svh"

module ssr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input ssr_pkg::out_word_t out_data
);

    // Hold a stalled output word.
    `SSR_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data))
    // Each word is either a data byte or the end marker, never both.
    `SSR_ASSERT(a_kind, out_valid |-> (out_data.byte_valid != out_data.final_result))
    // The end marker carries a zero byte.
    `SSR_ASSERT(a_marker_zero, out_valid && out_data.final_result |-> out_data.out_byte == '0)
    // Drop output while in reset.
    `SSR_ASSERT_RST(a_reset_quiet, !rst_n |-> !out_valid)

endmodule

bind stream_substring_replace ssr_checker u_ssr_checker (.*);
